// File: rtl/bffsc_pkg.sv
`default_nettype none

package bffsc_pkg;

    localparam int WORD_BITS = 32;
    localparam int OFFS_W    = 5;   // log2(WORD_BITS)
    localparam int SEL_W     = 5;   // word select carried by a 10-bit bit index
    localparam int IDX_W     = 10;
    localparam int WIU_W     = 6;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        CMD_SET      = 2'd0,
        CMD_CLR      = 2'd1,
        CMD_FIND_SET = 2'd2,
        CMD_FIND_CLR = 2'd3
    } cmd_t;

    // Control broadcast to every cell of the ring
    typedef struct packed {
        logic             shift;     // rotate ring by one word
        logic             wr;        // single-bit update
        logic             set_bit;   // 1: set, 0: clear
        logic [SEL_W-1:0] word_sel;
        logic [OFFS_W-1:0] bit_sel;
    } cell_ctrl_t;

    // Control for the scanner at the head of the ring
    typedef struct packed {
        logic start;     // clear result before a new scan
        logic step;      // head word is valid this cycle
        logic want_set;  // 1: look for a one, 0: look for a zero
    } scan_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bffsc_cell.sv
`default_nettype none

module bffsc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bffsc_pkg::cell_ctrl_t ctrl,
    input  wire bffsc_pkg::word_t     next_word,
    output      bffsc_pkg::word_t     word
);
    import bffsc_pkg::*;

    word_t word_reg;
    word_t word_next;
    word_t mask;

    assign mask = word_t'(1) << ctrl.bit_sel;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.shift)
        begin
            word_next = next_word;
        end
        else if (ctrl.wr && (int'(ctrl.word_sel) == CELL_INDEX))
        begin
            if (ctrl.set_bit)
            begin
                word_next = word_reg | mask;
            end
            else
            begin
                word_next = word_reg & ~mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// File: rtl/bffsc_scan.sv
`default_nettype none

module bffsc_scan #(
    parameter int KW = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bffsc_pkg::scan_ctrl_t         ctrl,
    input  wire bffsc_pkg::word_t              head_word,
    input  wire logic [KW-1:0]                 word_num,
    input  wire logic [bffsc_pkg::WIU_W-1:0]   words_in_use,
    output      logic                          found,
    output      logic [bffsc_pkg::IDX_W-1:0]   position
);
    import bffsc_pkg::*;

    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  pos_next;
    word_t             cand;
    word_t             lowest;
    logic [OFFS_W-1:0] offs;
    logic              in_range;
    logic              hit;

    assign cand     = ctrl.want_set ? head_word : ~head_word;
    // isolate lowest one, then encode the one-hot
    assign lowest   = cand & (~cand + word_t'(1));
    assign in_range = int'(word_num) < int'(words_in_use);
    assign hit      = ctrl.step && !found_reg && in_range && (cand != '0);

    always_comb
    begin
        offs = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lowest[i])
            begin
                offs = offs | OFFS_W'(i);
            end
        end
    end

    always_comb
    begin
        found_next = found_reg;
        pos_next   = pos_reg;
        if (ctrl.start)
        begin
            found_next = 1'b0;
            pos_next   = '0;
        end
        else if (hit)
        begin
            found_next = 1'b1;
            pos_next   = IDX_W'({word_num, offs});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    assign found    = found_reg;
    assign position = pos_reg;

endmodule

`default_nettype wire

// File: rtl/bitmap_find_first_set_clear.sv
// Bit map of NUM_WORDS 32-bit words with set, clear, find-first-set and
// find-first-clear commands.
// Input channel: in_valid/in_stall carry command and bit_addr. A word is
//   taken at a clock edge with in_valid high and in_stall low.
// Set/clear: written in the accepting cycle; next word may follow at once.
//   Indexes past the end of the map are dropped. No result.
// Search: the words sit in a ring of cells that rotates one position per
//   cycle while searching; the scanner at the head checks one word a cycle, so
//   a search holds the input until its result is loaded into the output
//   register, and the ring is back in place when it ends. Only words below
//   words_in_use count.
// Output channel: out_valid/out_stall carry found and position (0 if not
//   found). The result sits in an output register; while it waits the block
//   still takes set/clear words and starts the next search, which then holds
//   at its end until the register frees up.
// Config: cfg_write/cfg_data load words_in_use; write only while idle.
// Reset: map all zeros, words_in_use = 32, no result pending.
`default_nettype none

module bitmap_find_first_set_clear #(
    parameter int NUM_WORDS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [bffsc_pkg::WIU_W-1:0]     cfg_data,
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire logic [1:0]                      command,
    input  wire logic [bffsc_pkg::IDX_W-1:0]     bit_addr,
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic                            found,
    output      logic [bffsc_pkg::IDX_W-1:0]     position
);
    import bffsc_pkg::*;

    localparam int KW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              sense_reg, sense_next;
    logic [WIU_W-1:0]  wiu_reg;
    logic              oval_reg, oval_next;
    logic              ofound_reg;
    logic [IDX_W-1:0]  opos_reg;

    logic              in_acc;
    logic              is_search;
    logic              out_free;
    logic              load_out;
    cell_ctrl_t        cctl;
    scan_ctrl_t        sctl;
    word_t             ring [NUM_WORDS];
    logic              scan_found;
    logic [IDX_W-1:0]  scan_pos;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign is_search = (cmd_t'(command) == CMD_FIND_SET) ||
                       (cmd_t'(command) == CMD_FIND_CLR);
    assign out_free  = !oval_reg || !out_stall;
    assign load_out  = (state_reg == ST_HOLD) && out_free;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        sense_next = sense_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && is_search)
                begin
                    state_next = ST_SCAN;
                    k_next     = '0;
                    sense_next = (cmd_t'(command) == CMD_FIND_SET);
                end
            end
            ST_SCAN:
            begin
                if (k_reg == KW'(NUM_WORDS - 1))
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cell and scanner controls
    always_comb
    begin
        cctl.shift    = (state_reg == ST_SCAN);
        cctl.wr       = in_acc && !is_search;
        cctl.set_bit  = (cmd_t'(command) == CMD_SET);
        cctl.word_sel = bit_addr[IDX_W-1:OFFS_W];
        cctl.bit_sel  = bit_addr[OFFS_W-1:0];
        sctl.start    = in_acc && is_search;
        sctl.step     = (state_reg == ST_SCAN);
        sctl.want_set = sense_reg;
    end

    always_comb
    begin
        oval_next = oval_reg;
        if (load_out)
        begin
            oval_next = 1'b1;
        end
        else if (oval_reg && !out_stall)
        begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            sense_reg <= 1'b0;
            wiu_reg   <= WIU_W'(32);
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            sense_reg <= sense_next;
            oval_reg  <= oval_next;
            if (cfg_write)
            begin
                wiu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            ofound_reg <= scan_found;
            opos_reg   <= scan_pos;
        end
    end

    // ring of word cells: cell i takes cell i+1 on a rotate, head is cell 0
    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_cell
        bffsc_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cctl),
            .next_word (ring[(i + 1) % NUM_WORDS]),
            .word      (ring[i])
        );
    end

    bffsc_scan #(
        .KW (KW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (sctl),
        .head_word    (ring[0]),
        .word_num     (k_reg),
        .words_in_use (wiu_reg),
        .found        (scan_found),
        .position     (scan_pos)
    );

    assign out_valid = oval_reg;
    assign found     = ofound_reg;
    assign position  = opos_reg;

endmodule

`default_nettype wire

// File: rtl/bffsc_checker.sv
`default_nettype none

module bffsc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic [1:0]                   command,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic                         found,
    input wire logic [bffsc_pkg::IDX_W-1:0]  position
);
    import bffsc_pkg::*;

    // a waiting result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
        else $error("result changed while stalled");

    // a miss reports position zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("miss with nonzero position");

    // a search occupies the input side
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (command == CMD_FIND_SET || command == CMD_FIND_CLR) |=> in_stall)
        else $error("input free right after search");

    // set/clear never blocks the next word
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (command == CMD_SET || command == CMD_CLR) |=> !in_stall)
        else $error("input stalled after set/clear");

    // results only appear at the end of a search
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a search");

endmodule

bind bitmap_find_first_set_clear bffsc_checker u_bffsc_checker (.*);

`default_nettype wire
